FILE: rtl/lct_pkg.sv
// shared constants, types and fixed-point helpers for the cycle table oscillator
`timescale 1ns / 1ps

package lct_pkg;

  // store and number formats
  localparam int DEPTH       = 4096;
  localparam int PHASE_BITS  = 24;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = ADDR_W + 1;

  // configuration port and register widths
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int PINC_W     = 24;
  localparam int CLEN_W     = 13;

  // command fields
  localparam int CMD_W    = 2;
  localparam int OFFSET_W = 12;

  // shape arithmetic: at most 30 phase bits take part
  localparam int PB_USE = (PHASE_BITS > 30) ? 30 : PHASE_BITS;
  localparam int F_BITS = SAMPLE_BITS - 1;
  localparam int T_W    = PB_USE + 3;
  localparam int AT_W   = PB_USE + 1;
  localparam int SQ_W   = 2 * PB_USE + 2;
  localparam int RS_W   = 2 * PB_USE + 1;

  localparam logic signed [T_W-1:0] T_ONE   = T_W'(1) << PB_USE;
  localparam logic signed [T_W-1:0] T_THREE = T_ONE + (T_ONE <<< 1);
  localparam logic [RS_W-1:0]       SINE_TOP = RS_W'(1) << (2 * PB_USE);
  localparam logic [F_BITS:0]       SAT_FULL = (F_BITS + 1)'(1) << F_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_REGEN   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_SET     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC = 2'd0,
    REG_WAVEFORM  = 2'd1,
    REG_CYCLE_LEN = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_DRAIN
  } state_t;

  // one write beat into the cycle store
  typedef struct packed {
    logic                   en;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] data;
  } mem_wr_t;

  // rescale a magnitude with 'from' fraction bits to F_BITS, halves away from zero
  function automatic logic [F_BITS:0] rescale(input logic [RS_W-1:0] mag, input int from);
    logic [RS_W:0] w;
    logic [RS_W:0] half;
    w    = {1'b0, mag};
    half = '0;
    if (from > F_BITS) begin
      half = (RS_W + 1)'(1) << (from - F_BITS - 1);
      w    = (w + half) >> (from - F_BITS);
    end else begin
      w = w << (F_BITS - from);
    end
    return w[F_BITS:0];
  endfunction

  // clamp to +1.0 - lsb or -1.0 and apply the sign
  function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic neg,
                                                             input logic [F_BITS:0] mag);
    logic [F_BITS:0] m;
    if (neg) begin
      m = (mag > SAT_FULL) ? SAT_FULL : mag;
      return signed'((~m) + (F_BITS + 1)'(1));
    end else begin
      m = (mag > SAT_FULL - 1'b1) ? (SAT_FULL - 1'b1) : mag;
      return signed'(m);
    end
  endfunction

endpackage

FILE: rtl/lct_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module lct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lct_shape.sv
// three stage waveform pipeline: phase to q1.15 sample and store write beat
`timescale 1ns / 1ps

module lct_shape import lct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue,
  input  logic [ADDR_W-1:0]     issue_idx,
  input  logic [PHASE_BITS-1:0] phase,
  input  wave_t                 wave,
  output mem_wr_t               wr,
  output logic                  busy
);

  logic [PB_USE-1:0]      u;
  logic                   first;
  logic signed [T_W-1:0]  ut;
  logic signed [T_W-1:0]  t;
  logic signed [T_W-1:0]  t_abs;
  logic                   tri_neg;

  logic                   s1_valid;
  logic [ADDR_W-1:0]      s1_idx;
  logic [AT_W-1:0]        s1_at;
  logic                   s1_first;
  logic                   s1_tri_neg;
  logic [PB_USE-1:0]      s1_u;
  wave_t                  s1_wave;

  logic                   s2_valid;
  logic [ADDR_W-1:0]      s2_idx;
  logic [SQ_W-1:0]        s2_sq;
  logic [AT_W-1:0]        s2_at;
  logic                   s2_first;
  logic                   s2_tri_neg;
  logic [PB_USE-1:0]      s2_u;
  wave_t                  s2_wave;

  logic [RS_W-1:0]        sine_val;
  logic [SAMPLE_BITS-1:0] sample_val;

  // stage 1 input: distance of 4p from the nearest odd quarter
  always_comb begin
    u       = phase[PHASE_BITS-1 -: PB_USE];
    first   = ~u[PB_USE-1];
    ut      = signed'({3'b000, u});
    t       = (ut <<< 2) - (first ? T_ONE : T_THREE);
    t_abs   = t[T_W-1] ? -t : t;
    tri_neg = first ? t[T_W-1] : (~t[T_W-1] && (t != '0));
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // stage 1 and stage 2 payload, square registered before use
  always_ff @(posedge clk) begin
    s1_idx     <= issue_idx;
    s1_at      <= t_abs[AT_W-1:0];
    s1_first   <= first;
    s1_tri_neg <= tri_neg;
    s1_u       <= u;
    s1_wave    <= wave;

    s2_idx     <= s1_idx;
    s2_sq      <= s1_at * s1_at;
    s2_at      <= s1_at;
    s2_first   <= s1_first;
    s2_tri_neg <= s1_tri_neg;
    s2_u       <= s1_u;
    s2_wave    <= s1_wave;
  end

  // stage 3: shape select, round and saturate
  always_comb begin
    sine_val = SINE_TOP - s2_sq[RS_W-1:0];
    case (s2_wave)
      WAVE_SINE: begin
        sample_val = saturate(~s2_first, rescale(sine_val, 2 * PB_USE));
      end
      WAVE_TRI: begin
        sample_val = saturate(s2_tri_neg, rescale(RS_W'(s2_at), PB_USE));
      end
      WAVE_SQUARE: begin
        sample_val = saturate(~s2_first, SAT_FULL);
      end
      default: begin
        sample_val = saturate(1'b0, rescale(RS_W'(s2_u), PB_USE));
      end
    endcase
  end

  assign wr.en   = s2_valid;
  assign wr.addr = s2_idx;
  assign wr.data = sample_val;
  assign busy    = s1_valid | s2_valid;

endmodule

FILE: rtl/lfo_cycle_table_oscillator_core.sv
// top level: command sequencer, pointer logic and cycle store of the table lfo
`timescale 1ns / 1ps

// Low-frequency oscillator that plays a stored cycle. Read and set-pointer
// commands are taken in any cycle while busy is low, one per cycle, and each
// gives its result beat (done high, sample and read_position) in the cycle
// after start; the read comes from the cycle store's registered read port.
// A regenerate or restart command raises busy until its beat, which comes once
// cycle_length entries (clamped to one..DEPTH) are written: the store takes one
// write per cycle, fed by a three stage shape pipeline, and the pipeline is
// drained before the beat. Entries above the longest length generated so far
// read as zero, so the store needs no clearing after reset. done is high for
// exactly one cycle per beat and cannot be held off; configuration writes are
// meant for times when busy is low and no beat is still due.
module lfo_cycle_table_oscillator_core import lct_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [CMD_W-1:0]              cmd,
  input  logic [OFFSET_W-1:0]           offset,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic [ADDR_W-1:0]             read_position
);

  state_t                 state;
  state_t                 state_next;

  logic [PINC_W-1:0]      phase_increment;
  wave_t                  waveform;
  logic [CLEN_W-1:0]      cycle_length;

  logic [PHASE_BITS-1:0]  phase;
  logic [ADDR_W-1:0]      rp;
  logic [LEN_W-1:0]       gen_len;
  logic [LEN_W-1:0]       fill;
  logic [LEN_W-1:0]       run_len;
  logic [LEN_W-1:0]       gen_cnt;

  logic                   out_hit;
  logic [ADDR_W-1:0]      out_pos;

  logic                   accept;
  cmd_t                   cmd_in;
  logic [LEN_W-1:0]       len_clamped;
  logic [LEN_W-1:0]       wrap;
  logic [LEN_W-1:0]       rp_inc;
  logic [ADDR_W-1:0]      rp_step;
  logic                   rd_en;
  logic                   issue;
  logic                   gen_finish;
  logic                   shape_busy;
  mem_wr_t                wr;
  logic [SAMPLE_BITS-1:0] ram_q;

  assign cmd_in = cmd_t'(cmd);
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // requested length limited to one..DEPTH
  always_comb begin
    if (cycle_length == '0) begin
      len_clamped = LEN_W'(1);
    end else if (32'(cycle_length) > DEPTH) begin
      len_clamped = LEN_W'(DEPTH);
    end else begin
      len_clamped = LEN_W'(cycle_length);
    end
  end

  // read pointer advance with wrap at the generated length
  always_comb begin
    wrap    = (gen_len != '0) ? gen_len : LEN_W'(DEPTH);
    rp_inc  = {1'b0, rp} + LEN_W'(1);
    rp_step = (rp_inc >= wrap) ? '0 : rp_inc[ADDR_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      waveform        <= WAVE_SINE;
      cycle_length    <= CLEN_W'(1);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_PHASE_INC: phase_increment <= cfg_data[PINC_W-1:0];
        REG_WAVEFORM:  waveform        <= wave_t'(cfg_data[1:0]);
        REG_CYCLE_LEN: cycle_length    <= cfg_data[CLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    issue      = 1'b0;
    gen_finish = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_in == CMD_READ) begin
            rd_en = 1'b1;
          end else if (cmd_in == CMD_REGEN || cmd_in == CMD_RESTART) begin
            state_next = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        issue = 1'b1;
        if (gen_cnt == run_len - LEN_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!shape_busy) begin
          gen_finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // pointer, phase, lengths and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      rp      <= '0;
      gen_len <= '0;
      fill    <= '0;
      run_len <= LEN_W'(1);
      gen_cnt <= '0;
      done    <= 1'b0;
      out_hit <= 1'b0;
      out_pos <= '0;
    end else begin
      done    <= 1'b0;
      out_hit <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_in)
              CMD_READ: begin
                rp      <= rp_step;
                out_pos <= rp_step;
                out_hit <= ({1'b0, rp} < fill);
                done    <= 1'b1;
              end
              CMD_SET: begin
                rp      <= offset;
                out_pos <= offset;
                done    <= 1'b1;
              end
              CMD_RESTART: begin
                phase   <= '0;
                run_len <= len_clamped;
                gen_cnt <= '0;
              end
              default: begin
                run_len <= len_clamped;
                gen_cnt <= '0;
              end
            endcase
          end
        end
        ST_GEN: begin
          phase   <= phase + PHASE_BITS'(phase_increment);
          gen_cnt <= gen_cnt + LEN_W'(1);
        end
        ST_DRAIN: begin
          if (gen_finish) begin
            if (run_len < gen_len) begin
              rp      <= '0;
              out_pos <= '0;
            end else begin
              out_pos <= rp;
            end
            gen_len <= run_len;
            if (run_len > fill) begin
              fill <= run_len;
            end
            done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // waveform pipeline
  lct_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_idx (gen_cnt[ADDR_W-1:0]),
    .phase     (phase),
    .wave      (waveform),
    .wr        (wr),
    .busy      (shape_busy)
  );

  // cycle store
  lct_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rp),
    .rdata (ram_q)
  );

  // result payload: stored sample only for a read of a written entry
  assign sample        = out_hit ? signed'(ram_q) : '0;
  assign read_position = out_pos;

  // store writes only happen during a regenerate or restart
  a_write_in_regen: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state != ST_IDLE))
    else $error("cycle store write outside regenerate");

  // generated length never exceeds the written fill mark
  a_fill_covers: assert property (@(posedge clk) disable iff (rst)
    gen_len <= fill)
    else $error("generated length above fill mark");

  // read and set commands answer in the next cycle
  a_quick_beat: assert property (@(posedge clk) disable iff (rst)
    $past(accept && !rst && (cmd_in == CMD_READ || cmd_in == CMD_SET)) |-> done)
    else $error("missing result beat after read or set");

  // run length stays within the store
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN) |-> (run_len != '0 && 32'(run_len) <= DEPTH))
    else $error("regenerate length out of range");

  // reported position matches the live pointer during a beat
  a_pos_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (read_position == rp))
    else $error("reported position differs from pointer");

endmodule

FILE: dv/tb.sv
// self-checking testbench for the cycle table lfo core: directed and random command traffic
`timescale 1ns / 1ps

module tb;
  import lct_pkg::*;

  // register slot past the end of the list, writes to it must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int     RANDOM_ITEMS = 500;
  localparam int     DRAIN_LIMIT  = 20000;
  localparam longint RUN_LIMIT_NS = 64'd250_000_000;

  // fixed-point constants of the shape arithmetic
  localparam longint P_ONE  = longint'(1) << PHASE_BITS;
  localparam longint P_HALF = P_ONE / 2;
  localparam longint S_FULL = longint'(1) << F_BITS;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [ADDR_W-1:0]             position;
  } osc_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [CMD_W-1:0]              cmd = CMD_READ;
  logic [OFFSET_W-1:0]           offset = '0;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = REG_PHASE_INC;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          busy;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [ADDR_W-1:0]             read_position;

  // predictor state: registers, phase accumulator, stored cycle and read pointer
  logic [PINC_W-1:0]             step_reg;
  wave_t                         shape_reg;
  logic [CLEN_W-1:0]             len_reg;
  logic [PHASE_BITS-1:0]         acc_phase;
  logic signed [SAMPLE_BITS-1:0] wave_table [DEPTH];
  logic [ADDR_W-1:0]             play_ptr;
  int                            filled_len;

  osc_beat_t beats_due[$];

  int mismatches = 0;
  int beats_checked = 0;
  int n_read = 0;
  int n_regen = 0;
  int n_restart = 0;
  int n_set = 0;
  int longest_fill = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfo_cycle_table_oscillator_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .offset        (offset),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .sample        (sample),
    .read_position (read_position)
  );

  // one waveform point at phase ph, Q1.15 with round half away and saturation
  function automatic logic signed [SAMPLE_BITS-1:0] wave_point(input logic [PHASE_BITS-1:0] ph,
                                                               input wave_t shape);
    longint u;
    longint t;
    longint mag;
    logic   neg;
    logic   lower;
    u     = longint'({40'd0, ph});
    lower = (u < P_HALF);
    case (shape)
      WAVE_SINE: begin
        t = lower ? (4 * u - P_ONE) : (4 * u - 3 * P_ONE);
        if (t < 0) t = -t;
        mag = (P_ONE * P_ONE - t * t + (longint'(1) << (2 * PHASE_BITS - F_BITS - 1)))
              >> (2 * PHASE_BITS - F_BITS);
        neg = !lower;
      end
      WAVE_TRI: begin
        t   = lower ? (4 * u - P_ONE) : (3 * P_ONE - 4 * u);
        neg = (t < 0);
        if (neg) t = -t;
        mag = (t + (longint'(1) << (PHASE_BITS - F_BITS - 1))) >> (PHASE_BITS - F_BITS);
      end
      WAVE_SQUARE: begin
        mag = S_FULL;
        neg = !lower;
      end
      default: begin
        mag = (u + (longint'(1) << (PHASE_BITS - F_BITS - 1))) >> (PHASE_BITS - F_BITS);
        neg = 1'b0;
      end
    endcase
    if (neg) begin
      if (mag > S_FULL) mag = S_FULL;
      return SAMPLE_BITS'(-mag);
    end
    if (mag > S_FULL - 1) mag = S_FULL - 1;
    return SAMPLE_BITS'(mag);
  endfunction

  // write one cycle of the current shape into the table, phase carries on
  function automatic void fill_table();
    int n;
    int i;
    n = int'(len_reg);
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    for (i = 0; i < n; i++) begin
      wave_table[i] = wave_point(acc_phase, shape_reg);
      acc_phase     = acc_phase + step_reg;
    end
    if (n < filled_len) play_ptr = '0;
    filled_len = n;
    if (n > longest_fill) longest_fill = n;
  endfunction

  // expected result beat of one command, updating the predictor state
  function automatic osc_beat_t oscillator_step(input cmd_t op, input logic [OFFSET_W-1:0] off);
    osc_beat_t r;
    int        wrap_at;
    r.sample = '0;
    case (op)
      CMD_READ: begin
        wrap_at  = (filled_len != 0) ? filled_len : DEPTH;
        r.sample = wave_table[play_ptr];
        if (int'(play_ptr) + 1 >= wrap_at) play_ptr = '0;
        else play_ptr = play_ptr + 1'b1;
      end
      CMD_REGEN: fill_table();
      CMD_RESTART: begin
        acc_phase = '0;
        fill_table();
      end
      default: play_ptr = off;
    endcase
    r.position = play_ptr;
    return r;
  endfunction

  function automatic void predictor_reset();
    int i;
    step_reg   = '0;
    shape_reg  = WAVE_SINE;
    len_reg    = CLEN_W'(1);
    acc_phase  = '0;
    play_ptr   = '0;
    filled_len = 0;
    for (i = 0; i < DEPTH; i++) wave_table[i] = '0;
  endfunction

  // register write; callers must use it only while the block is idle, the task does not check busy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PHASE_INC: step_reg = val[PINC_W-1:0];
      REG_WAVEFORM:  shape_reg = wave_t'(val[1:0]);
      REG_CYCLE_LEN: len_reg = val[CLEN_W-1:0];
      default: ;
    endcase
  endtask

  // send one command beat; start stays high for a following beat
  task automatic issue(input cmd_t op, input logic [OFFSET_W-1:0] off);
    start     <= 1'b1;
    cmd       <= op;
    offset    <= off;
    cfg_write <= 1'b0;
    do @(posedge clk); while (busy);
    beats_due.push_back(oscillator_step(op, off));
    case (op)
      CMD_READ:    n_read++;
      CMD_REGEN:   n_regen++;
      CMD_RESTART: n_restart++;
      default:     n_set++;
    endcase
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start     <= 1'b0;
      cfg_write <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop sending until every due beat has come back
  task automatic settle();
    start     <= 1'b0;
    cfg_write <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_power_up_reads();
    write_reg(REG_SPARE, 24'hFFFFFF);
    issue(CMD_READ, '0);
    issue(CMD_READ, 12'hFFF);
    issue(CMD_SET, 12'hFFF);
    // nothing generated yet, so the pointer wraps at full depth
    issue(CMD_READ, '0);
  endtask

  task automatic test_shape_points();
    // quarter-cycle steps hit the peaks, the half-cycle edge and the troughs
    write_reg(REG_PHASE_INC, 24'h400000);
    write_reg(REG_WAVEFORM, CFG_W'(WAVE_SINE));
    write_reg(REG_CYCLE_LEN, 24'd4);
    issue(CMD_SET, '0);
    issue(CMD_RESTART, '0);
    repeat (4) issue(CMD_READ, '0);
    settle();
    write_reg(REG_WAVEFORM, {22'h3FFFFF, WAVE_TRI});
    issue(CMD_RESTART, '0);
    repeat (4) issue(CMD_READ, '0);
    settle();
    write_reg(REG_PHASE_INC, 24'h800000);
    write_reg(REG_WAVEFORM, CFG_W'(WAVE_SQUARE));
    write_reg(REG_CYCLE_LEN, 24'd2);
    issue(CMD_RESTART, '0);
    repeat (2) issue(CMD_READ, '0);
    settle();
    // largest step lands just below one full cycle
    write_reg(REG_PHASE_INC, 24'hFFFFFF);
    write_reg(REG_WAVEFORM, CFG_W'(WAVE_SAW));
    issue(CMD_RESTART, '0);
    repeat (2) issue(CMD_READ, '0);
  endtask

  task automatic test_length_limits();
    // zero length field acts as one
    write_reg(REG_CYCLE_LEN, 24'hFFE000);
    issue(CMD_REGEN, '0);
    issue(CMD_READ, '0);
    settle();
    // length far above the store is clipped to the full depth
    write_reg(REG_PHASE_INC, 24'h000123);
    write_reg(REG_CYCLE_LEN, 24'h001FFF);
    issue(CMD_REGEN, '0);
    issue(CMD_SET, 12'd100);
    settle();
    // a shorter fill pulls the pointer back to zero
    write_reg(REG_CYCLE_LEN, 24'd1);
    issue(CMD_REGEN, 12'hFFF);
    issue(CMD_READ, '0);
  endtask

  task automatic test_random_traffic();
    int                  sent;
    int                  burst;
    int                  big_left;
    int                  roll;
    int                  k;
    int                  n_phase;
    logic [CFG_W-1:0]    step_val;
    logic [CLEN_W-1:0]   len_val;
    logic [OFFSET_W-1:0] off;
    cmd_t                op;
    sent     = 0;
    burst    = 0;
    big_left = 3;
    while (sent < RANDOM_ITEMS) begin
      settle();
      // new register setting for this stretch
      roll = $urandom_range(0, 9);
      if (roll == 0) step_val = '0;
      else if (roll == 1) step_val = 24'hFFFFFF;
      else if (roll < 6) step_val = CFG_W'($urandom_range(1, 24'h03FFFF));
      else step_val = CFG_W'($urandom());
      roll = $urandom_range(0, 99);
      if (roll < 65) len_val = CLEN_W'($urandom_range(1, 32));
      else if (roll < 85) len_val = CLEN_W'($urandom_range(33, 400));
      else if (roll < 92) len_val = '0;
      else if (big_left > 0) begin
        big_left--;
        len_val = (roll < 96) ? CLEN_W'(DEPTH) : CLEN_W'($urandom_range(DEPTH + 1, 8191));
      end else begin
        len_val = CLEN_W'($urandom_range(1, 8));
      end
      write_reg(REG_PHASE_INC, step_val);
      write_reg(REG_WAVEFORM, CFG_W'($urandom()));
      write_reg(REG_CYCLE_LEN, {11'($urandom()), len_val});
      // fill first, then mostly reads over the new cycle
      issue($urandom_range(0, 1) ? CMD_RESTART : CMD_REGEN, OFFSET_W'($urandom()));
      sent++;
      n_phase = $urandom_range(20, 60);
      for (k = 0; k < n_phase; k++) begin
        if (burst == 0) begin
          pause($urandom_range(1, 6));
          burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        end
        roll = $urandom_range(0, 99);
        if (roll < 78) op = CMD_READ;
        else if (roll < 88) op = CMD_SET;
        else if (roll < 94) op = CMD_REGEN;
        else op = CMD_RESTART;
        if ($urandom_range(0, 1) && filled_len > 0)
          off = OFFSET_W'($urandom_range(0, filled_len - 1));
        else
          off = OFFSET_W'($urandom());
        issue(op, off);
        burst--;
        sent++;
        if (sent % 97 == 48) settle();
      end
    end
  endtask

  // compare every result beat with the oldest due beat
  always @(posedge clk) begin
    osc_beat_t want;
    if (!rst && done) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: sample %0d read_position %0d", sample, read_position);
        mismatches++;
      end else begin
        want = beats_due.pop_front();
        beats_checked++;
        if (sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, sample);
          mismatches++;
        end
        if (read_position !== want.position) begin
          $error("read_position: expected %0d, got %0d", want.position, read_position);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int guard;
    predictor_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_up_reads();
    settle();
    test_shape_points();
    settle();
    test_length_limits();
    settle();
    test_random_traffic();
    // wind down: nothing more to send
    start <= 1'b0;
    guard = 0;
    while (beats_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (beats_due.size() != 0) begin
      $error("%0d beats never arrived", beats_due.size());
      mismatches++;
    end
    $display("covered %0d reads, %0d regenerates, %0d restarts, %0d pointer loads",
             n_read, n_regen, n_restart, n_set);
    $display("%0d beats compared, longest cycle filled %0d samples", beats_checked, longest_fill);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(RUN_LIMIT_NS);
    $error("run timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lct_pkg.sv
rtl/lct_ram.sv
rtl/lct_shape.sv
rtl/lfo_cycle_table_oscillator_core.sv
dv/tb.sv
